// ===== design/qsl_pkg.sv =====
// Package for the quicksort sorter core: datapath select codes and the
// command and status structures between controller and datapath.
// No dependencies.
`default_nettype none

package qsl_pkg;

	localparam int DATA_W = 32;

	localparam logic [2:0] ADDR_CNT = 3'd0;
	localparam logic [2:0] ADDR_HI  = 3'd1;
	localparam logic [2:0] ADDR_M   = 3'd2;
	localparam logic [2:0] ADDR_K   = 3'd3;
	localparam logic [2:0] ADDR_J   = 3'd4;

	localparam logic [1:0] DATA_IN  = 2'd0;
	localparam logic [1:0] DATA_RD  = 2'd1;
	localparam logic [1:0] DATA_AM  = 2'd2;
	localparam logic [1:0] DATA_PIV = 2'd3;

	typedef struct packed {
		logic       load_wr;
		logic       sort_init;
		logic       ram_we;
		logic [2:0] addr_sel;
		logic [1:0] data_sel;
		logic       pivot_ld;
		logic       scan_init;
		logic       am_ld;
		logic       step_m;
		logic       step_k;
		logic       decide;
		logic       pop;
		logic       out_ld;
		logic       step_j;
		logic       set_clear;
	} ctrl_cmd_t;

	typedef struct packed {
		logic lo_lt_hi;
		logic m_eq_hi;
		logic k_eq_m;
		logic k_eq_hi;
		logic le_pivot;
		logic sp_zero;
		logic j_last;
		logic out_free;
	} ctrl_stat_t;

endpackage

`default_nettype wire

// ===== design/quicksort_lomuto_sorter_core.sv =====
// Loading accepts one word per cycle. The sort then runs on the single store port:
// each scanned element is read and then compared, and each swap writes both entries.
// Each output word is read from the registered store, then loaded into the free output register.
// Reset clears the item count, stack pointer, overflow flag and controller;
// store contents are undefined after reset. Depends on qsl_pkg, qsl_ctrl, qsl_datapath.
`default_nettype none

module quicksort_lomuto_sorter_core #(
	parameter int CAPACITY = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] value
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,  // [31:0] sorted_value
	output logic             m_axis_tlast,
	output logic             m_axis_tuser   // [0] overflowed
);
	import qsl_pkg::*;

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	qsl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_last (s_axis_tlast),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	qsl_datapath #(
		.CAPACITY(CAPACITY)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_value    (s_axis_tdata),
		.out_ready   (m_axis_tready),
		.out_value   (m_axis_tdata),
		.out_final   (m_axis_tlast),
		.out_overflow(m_axis_tuser),
		.out_valid   (m_axis_tvalid)
	);

endmodule

`default_nettype wire

// ===== design/qsl_ram.sv =====
// Generic single-port RAM with one write or read per cycle and a registered read.
// No dependencies.
`default_nettype none

module qsl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

// ===== design/qsl_datapath.sv =====
// Datapath of the quicksort sorter core: element store, range registers, range stack,
// partition indexes and the output register. Depends on qsl_pkg and qsl_ram.
`default_nettype none

module qsl_datapath #(
	parameter int CAPACITY = 64
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire qsl_pkg::ctrl_cmd_t      cmd,
	output qsl_pkg::ctrl_stat_t          stat,
	input  wire logic [31:0]             in_value,
	input  wire logic                    out_ready,
	output logic      [31:0]             out_value,
	output logic                         out_final,
	output logic                         out_overflow,
	output logic                         out_valid
);
	import qsl_pkg::*;

	localparam int IW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int PW  = IW + 2;
	localparam int SD  = IW + 1;
	localparam int SPW = $clog2(SD + 1);
	localparam int SIW = $clog2(SD);

	typedef struct packed {
		logic [IW-1:0] hi;
		logic [IW-1:0] lo;
	} range_t;

	logic [CW-1:0]        count_q;
	logic                 drop_q;
	logic signed [PW-1:0] lo_q;
	logic signed [PW-1:0] hi_q;
	logic [IW-1:0]        k_q;
	logic [IW-1:0]        m_q;
	logic [IW-1:0]        j_q;
	logic [DATA_W-1:0]    pivot_q;
	logic [DATA_W-1:0]    am_q;
	range_t               stack_q [SD];
	logic [SPW-1:0]       sp_q;
	logic [DATA_W-1:0]    out_value_q;
	logic                 out_final_q;
	logic                 out_overflow_q;
	logic                 out_valid_q;

	logic                 full;
	logic [IW-1:0]        ram_addr;
	logic [DATA_W-1:0]    ram_wdata;
	logic [DATA_W-1:0]    ram_rdata;
	logic                 ram_we;
	logic signed [PW-1:0] p_ext;
	logic signed [PW-1:0] p_inc;
	logic signed [PW-1:0] p_dec;
	logic signed [PW-1:0] left_len;
	logic signed [PW-1:0] right_len;
	logic [SPW-1:0]       sp_dec;
	range_t               push_rng;
	range_t               pop_rng;

	assign full = (count_q == CW'(CAPACITY));

	always_comb begin
		case (cmd.addr_sel)
			ADDR_CNT: ram_addr = count_q[IW-1:0];
			ADDR_HI:  ram_addr = hi_q[IW-1:0];
			ADDR_M:   ram_addr = m_q;
			ADDR_K:   ram_addr = k_q;
			ADDR_J:   ram_addr = j_q;
			default:  ram_addr = '0;
		endcase
		case (cmd.data_sel)
			DATA_IN:  ram_wdata = in_value;
			DATA_RD:  ram_wdata = ram_rdata;
			DATA_AM:  ram_wdata = am_q;
			DATA_PIV: ram_wdata = pivot_q;
			default:  ram_wdata = '0;
		endcase
	end

	assign ram_we = cmd.ram_we & ~(cmd.load_wr & full);

	qsl_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign p_ext     = PW'(k_q);
	assign p_inc     = p_ext + PW'(1);
	assign p_dec     = p_ext - PW'(1);
	assign left_len  = p_ext - lo_q;
	assign right_len = hi_q - p_ext;
	assign sp_dec    = sp_q - SPW'(1);
	assign pop_rng   = stack_q[sp_dec[SIW-1:0]];

	always_comb begin
		if (left_len < right_len) begin
			push_rng.lo = p_inc[IW-1:0];
			push_rng.hi = hi_q[IW-1:0];
		end else begin
			push_rng.lo = lo_q[IW-1:0];
			push_rng.hi = p_dec[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			drop_q      <= 1'b0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_wr) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.set_clear) begin
				count_q <= '0;
				drop_q  <= 1'b0;
			end
			if (cmd.sort_init) begin
				sp_q <= '0;
			end else if (cmd.decide && sp_q != SPW'(SD)) begin
				sp_q <= sp_q + SPW'(1);
			end else if (cmd.pop) begin
				sp_q <= sp_dec;
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sort_init) begin
			lo_q <= '0;
			hi_q <= PW'(count_q) - PW'(1);
			j_q  <= '0;
		end
		if (cmd.decide) begin
			if (sp_q != SPW'(SD)) begin
				stack_q[sp_q[SIW-1:0]] <= push_rng;
			end
			if (left_len < right_len) begin
				hi_q <= p_dec;
			end else begin
				lo_q <= p_inc;
			end
		end
		if (cmd.pop) begin
			lo_q <= PW'(pop_rng.lo);
			hi_q <= PW'(pop_rng.hi);
		end
		if (cmd.pivot_ld) begin
			pivot_q <= ram_rdata;
		end
		if (cmd.am_ld) begin
			am_q <= ram_rdata;
		end
		if (cmd.scan_init) begin
			k_q <= lo_q[IW-1:0];
			m_q <= lo_q[IW-1:0];
		end
		if (cmd.step_m) begin
			m_q <= m_q + IW'(1);
		end
		if (cmd.step_k) begin
			k_q <= k_q + IW'(1);
		end
		if (cmd.step_j) begin
			j_q <= j_q + IW'(1);
		end
		if (cmd.out_ld) begin
			out_value_q    <= ram_rdata;
			out_final_q    <= stat.j_last;
			out_overflow_q <= drop_q;
		end
	end

	assign stat.lo_lt_hi = (lo_q < hi_q);
	assign stat.m_eq_hi  = (PW'(m_q) == hi_q);
	assign stat.k_eq_m   = (k_q == m_q);
	assign stat.k_eq_hi  = (PW'(k_q) == hi_q);
	assign stat.le_pivot = ($signed(ram_rdata) <= $signed(pivot_q));
	assign stat.sp_zero  = (sp_q == '0);
	assign stat.j_last   = ((CW'(j_q) + CW'(1)) == count_q);
	assign stat.out_free = ~out_valid_q | out_ready;

	assign out_value    = out_value_q;
	assign out_final    = out_final_q;
	assign out_overflow = out_overflow_q;
	assign out_valid    = out_valid_q;

endmodule

`default_nettype wire

// ===== design/qsl_ctrl.sv =====
// Controller of the quicksort sorter core: loading, partition sequencing, range
// stack handling and output. Depends on qsl_pkg.
`default_nettype none

module qsl_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_last,
	output logic                     in_ready,
	input  wire qsl_pkg::ctrl_stat_t stat,
	output qsl_pkg::ctrl_cmd_t       cmd
);
	import qsl_pkg::*;

	localparam logic [3:0] ST_LOAD     = 4'd0;
	localparam logic [3:0] ST_INIT     = 4'd1;
	localparam logic [3:0] ST_LOOP     = 4'd2;
	localparam logic [3:0] ST_PIV_RD   = 4'd3;
	localparam logic [3:0] ST_PIV_LD   = 4'd4;
	localparam logic [3:0] ST_SCAN_RD  = 4'd5;
	localparam logic [3:0] ST_SCAN_CMP = 4'd6;
	localparam logic [3:0] ST_SW_WM    = 4'd7;
	localparam logic [3:0] ST_SW_WK    = 4'd8;
	localparam logic [3:0] ST_FIN_RD   = 4'd9;
	localparam logic [3:0] ST_FIN_WH   = 4'd10;
	localparam logic [3:0] ST_FIN_WK   = 4'd11;
	localparam logic [3:0] ST_DECIDE   = 4'd12;
	localparam logic [3:0] ST_OUT_RD   = 4'd13;
	localparam logic [3:0] ST_OUT_LD   = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == ST_LOAD);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					cmd.load_wr  = 1'b1;
					cmd.ram_we   = 1'b1;
					cmd.addr_sel = ADDR_CNT;
					cmd.data_sel = DATA_IN;
					if (in_last) begin
						state_d = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				cmd.sort_init = 1'b1;
				state_d       = ST_LOOP;
			end
			ST_LOOP: begin
				if (stat.lo_lt_hi) begin
					state_d = ST_PIV_RD;
				end else if (stat.sp_zero) begin
					state_d = ST_OUT_RD;
				end else begin
					cmd.pop = 1'b1;
				end
			end
			ST_PIV_RD: begin
				cmd.addr_sel = ADDR_HI;
				state_d      = ST_PIV_LD;
			end
			ST_PIV_LD: begin
				cmd.pivot_ld  = 1'b1;
				cmd.scan_init = 1'b1;
				state_d       = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				if (stat.m_eq_hi) begin
					state_d = ST_FIN_RD;
				end else begin
					cmd.addr_sel = ADDR_M;
					state_d      = ST_SCAN_CMP;
				end
			end
			ST_SCAN_CMP: begin
				if (stat.le_pivot && !stat.k_eq_m) begin
					cmd.am_ld    = 1'b1;
					cmd.addr_sel = ADDR_K;
					state_d      = ST_SW_WM;
				end else begin
					cmd.step_m = 1'b1;
					cmd.step_k = stat.le_pivot;
					state_d    = ST_SCAN_RD;
				end
			end
			ST_SW_WM: begin
				cmd.ram_we   = 1'b1;
				cmd.addr_sel = ADDR_M;
				cmd.data_sel = DATA_RD;
				state_d      = ST_SW_WK;
			end
			ST_SW_WK: begin
				cmd.ram_we   = 1'b1;
				cmd.addr_sel = ADDR_K;
				cmd.data_sel = DATA_AM;
				cmd.step_k   = 1'b1;
				cmd.step_m   = 1'b1;
				state_d      = ST_SCAN_RD;
			end
			ST_FIN_RD: begin
				if (stat.k_eq_hi) begin
					state_d = ST_DECIDE;
				end else begin
					cmd.addr_sel = ADDR_K;
					state_d      = ST_FIN_WH;
				end
			end
			ST_FIN_WH: begin
				cmd.ram_we   = 1'b1;
				cmd.addr_sel = ADDR_HI;
				cmd.data_sel = DATA_RD;
				state_d      = ST_FIN_WK;
			end
			ST_FIN_WK: begin
				cmd.ram_we   = 1'b1;
				cmd.addr_sel = ADDR_K;
				cmd.data_sel = DATA_PIV;
				state_d      = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_LOOP;
			end
			ST_OUT_RD: begin
				if (stat.out_free) begin
					cmd.addr_sel = ADDR_J;
					state_d      = ST_OUT_LD;
				end
			end
			ST_OUT_LD: begin
				cmd.out_ld = 1'b1;
				if (stat.j_last) begin
					cmd.set_clear = 1'b1;
					state_d       = ST_LOAD;
				end else begin
					cmd.step_j = 1'b1;
					state_d    = ST_OUT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== sim/qsl_sort_checker.sv =====
// Checker for the quicksort sorter core: watches both stream channels, predicts the
// sorted words of each set with its own Lomuto quicksort and compares them in order.
// Stands alone; instantiated by quicksort_lomuto_sorter_core_tb.
module qsl_sort_checker #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,  // [31:0] sorted_value
	input  logic        m_axis_tlast,
	input  logic        m_axis_tuser,  // [0] overflowed
	output int unsigned mismatches,
	output int unsigned awaited,
	output int unsigned sets_done,
	output int unsigned words_done
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANGE_DEPTH = 7;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic signed [31:0] value;
		logic               final_word;
		logic               overflowed;
	} sorted_word_t;

	logic signed [31:0] set_store [CAPACITY];
	int                 loaded;
	logic               dropped;
	sorted_word_t       sorted_q [$];

	initial begin
		mismatches = 0;
		awaited = 0;
		sets_done = 0;
		words_done = 0;
		loaded = 0;
		dropped = 1'b0;
	end

	task automatic flag_mismatch(input string what, input sorted_word_t want,
			input sorted_word_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("%0t mismatch (%s): expected value %0d last %0b overflow %0b,",
				$realtime, what, want.value, want.final_word, want.overflowed);
			$display("    got value %0d last %0b overflow %0b",
				got.value, got.final_word, got.overflowed);
		end
	endtask

	task automatic swap_entries(input int a, input int b);
		logic signed [31:0] t;
		t = set_store[a];
		set_store[a] = set_store[b];
		set_store[b] = t;
	endtask

	// Lomuto partition about the last entry of each range; the larger side is parked
	// on a bounded range stack while the smaller side is worked first.
	task automatic lomuto_sort(input int count);
		int                 lo;
		int                 hi;
		int                 k;
		int                 p;
		int                 sp;
		bit                 done;
		int                 park_lo [RANGE_DEPTH];
		int                 park_hi [RANGE_DEPTH];
		logic signed [31:0] pivot;
		lo = 0;
		hi = count - 1;
		sp = 0;
		done = 1'b0;
		while (!done) begin
			while (lo < hi) begin
				pivot = set_store[hi];
				k = lo;
				for (int m = lo; m < hi; m++) begin
					if (set_store[m] <= pivot) begin
						swap_entries(k, m);
						k++;
					end
				end
				swap_entries(k, hi);
				p = k;
				if (p - lo < hi - p) begin
					if (sp < RANGE_DEPTH) begin
						park_lo[sp] = p + 1;
						park_hi[sp] = hi;
						sp++;
					end
					hi = p - 1;
				end else begin
					if (sp < RANGE_DEPTH) begin
						park_lo[sp] = lo;
						park_hi[sp] = p - 1;
						sp++;
					end
					lo = p + 1;
				end
			end
			if (sp == 0) begin
				done = 1'b1;
			end else begin
				sp--;
				lo = park_lo[sp];
				hi = park_hi[sp];
			end
		end
	endtask

	always @(posedge clk) begin
		sorted_word_t got;
		sorted_word_t want;
		if (!arst_n) begin
			loaded = 0;
			dropped = 1'b0;
			sorted_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{value: m_axis_tdata, final_word: m_axis_tlast,
					overflowed: m_axis_tuser};
				if (sorted_q.size() == 0) begin
					flag_mismatch("word with nothing awaited", '0, got);
				end else begin
					want = sorted_q.pop_front();
					words_done++;
					if (got !== want) begin
						flag_mismatch("sorted word", want, got);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (loaded < CAPACITY) begin
					set_store[loaded] = s_axis_tdata;
					loaded++;
				end else begin
					dropped = 1'b1;
				end
				if (s_axis_tlast) begin
					lomuto_sort(loaded);
					for (int i = 0; i < loaded; i++) begin
						sorted_q.push_back('{value: set_store[i],
							final_word: (i == loaded - 1), overflowed: dropped});
					end
					sets_done++;
					loaded = 0;
					dropped = 1'b0;
				end
			end
		end
		awaited <= sorted_q.size();
	end
endmodule

// ===== sim/quicksort_lomuto_sorter_core_tb.sv =====
// Testbench top for quicksort_lomuto_sorter_core: drives sets of words with random
// idling on both channels and gives the verdict; depends on qsl_sort_checker.
module quicksort_lomuto_sorter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 64;
	localparam int DIRECTED_ITEMS = 22;
	localparam int RANDOM_ITEMS = 258;
	localparam int CALM_TAIL = 40;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum int {
		FILL_RANDOM,
		FILL_NARROW,
		FILL_EXTREME,
		FILL_RISING
	} fill_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tready = 1'b0;
	wire         s_axis_tready;
	wire         m_axis_tvalid;
	wire  [31:0] m_axis_tdata;
	wire         m_axis_tlast;
	wire         m_axis_tuser;

	int unsigned mismatches;
	int unsigned awaited;
	int unsigned sets_done;
	int unsigned words_done;
	int unsigned cycles = 0;
	int unsigned items_sent = 0;
	int          sink_hold = 0;
	bit          calm = 1'b0;

	always #4 clk = ~clk;

	quicksort_lomuto_sorter_core #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	qsl_sort_checker #(
		.CAPACITY(CAPACITY)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.mismatches   (mismatches),
		.awaited      (awaited),
		.sets_done    (sets_done),
		.words_done   (words_done)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("quicksort_lomuto_sorter_core regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			sink_hold <= $urandom_range(0, 4);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_word(input logic [31:0] value, input logic last);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		calm = items_sent >= DIRECTED_ITEMS + RANDOM_ITEMS - CALM_TAIL;
	endtask

	task automatic send_set(input int count, input fill_mode_t mode);
		logic [31:0] value;
		for (int i = 0; i < count; i++) begin
			case (mode)
				FILL_NARROW: begin
					value = $urandom_range(0, 8) - 4;
				end
				FILL_EXTREME: begin
					case ($urandom_range(0, 3))
						0: value = 32'h8000_0000;
						1: value = 32'h7fff_ffff;
						2: value = 32'h0000_0000;
						default: value = 32'hffff_ffff;
					endcase
				end
				FILL_RISING: begin
					value = i * 7 - 100;
				end
				default: begin
					value = $urandom;
				end
			endcase
			send_word(value, i == count - 1);
		end
	endtask

	initial begin
		int set_idx;
		int count;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(32'h8000_0000, 1'b1);
		send_word(32'h7fff_ffff, 1'b0);
		send_word(32'h8000_0000, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'hffff_ffff, 1'b0);
		send_word(32'h0000_0001, 1'b0);
		send_word(32'h7fff_ffff, 1'b0);
		send_word(32'h8000_0000, 1'b1);
		for (int i = 0; i < 4; i++) begin
			send_word(32'd5, i == 3);
		end
		for (int i = 0; i < 5; i++) begin
			send_word(i - 2, i == 4);
		end
		for (int i = 0; i < 5; i++) begin
			send_word(2 - i, i == 4);
		end

		// A full store and one set whose last two words, the last one included,
		// arrive with the store already full.
		set_idx = 0;
		while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			if (set_idx == 2) begin
				count = CAPACITY;
			end else if (set_idx == 5) begin
				count = CAPACITY + 2;
			end else if ($urandom_range(0, 7) == 0) begin
				count = $urandom_range(13, 40);
			end else begin
				count = $urandom_range(1, 12);
			end
			send_set(count, fill_mode_t'($urandom_range(0, 3)));
			set_idx++;
		end
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sorted %0d sets, %0d words checked: single words, duplicates, extremes,",
			sets_done, words_done);
		$display("rising and falling runs, a full store and a set with dropped words.");
		if (mismatches == 0 && awaited == 0) begin
			$display("quicksort_lomuto_sorter_core regression: pass");
		end else begin
			$display("quicksort_lomuto_sorter_core regression: fail");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
design/qsl_pkg.sv
design/qsl_ram.sv
design/qsl_datapath.sv
design/qsl_ctrl.sv
design/quicksort_lomuto_sorter_core.sv
sim/qsl_sort_checker.sv
sim/quicksort_lomuto_sorter_core_tb.sv
